// File: hw/rtl/assert_macros.svh
// Assertion helpers sampled on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define LBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LBP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`endif

// File: hw/rtl/lbp_pkg.sv
`default_nettype none
package lbp_pkg;
  localparam int unsigned StateW  = 6;
  localparam int unsigned LabelW  = 24;
  localparam int unsigned WeightW = 24;
  localparam int unsigned CostW   = 32;
  localparam int unsigned Depth   = 64;
  localparam int unsigned DepW    = 7;

  localparam logic [1:0] ACT_ARC    = 2'd0;
  localparam logic [1:0] ACT_MARK   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [1:0] KIND_ARC   = 2'd0;
  localparam logic [1:0] KIND_FINAL = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  typedef enum logic [1:0] {OP_ARC, OP_MARK, OP_FINISH} op_e;

  typedef struct packed {
    op_e                 op;
    logic                err;
    logic [StateW-1:0]   from_state;
    logic [StateW-1:0]   to_state;
    logic [WeightW-1:0]  weight;
    logic [LabelW-1:0]   in_label;
    logic [LabelW-1:0]   out_label;
  } cmd_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [LabelW-1:0]  in_label;
    logic [LabelW-1:0]  out_label;
  } arc_info_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RELAX, B_MARK, B_FINISH, B_TRACE, B_TNEXT,
    B_ERD1, B_ERD2, B_ERD3, B_FINAL, B_OUT
  } back_state_e;
endpackage
`default_nettype wire

// File: hw/rtl/lbp_front.sv
`default_nettype none
module lbp_front #(
  parameter int MAX_STATES = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic [lbp_pkg::StateW-1:0] from_state_i,
  input  wire logic [lbp_pkg::StateW-1:0] to_state_i,
  input  wire logic [lbp_pkg::WeightW-1:0] arc_weight_i,
  input  wire logic [lbp_pkg::LabelW-1:0] in_label_i,
  input  wire logic [lbp_pkg::LabelW-1:0] out_label_i,
  output logic                            push_o,
  input  wire logic                       full_i,
  output lbp_pkg::cmd_t                   cmd_o
);
  import lbp_pkg::*;

  logic [StateW-1:0] prev_q, prev_d;
  logic              err_q, err_d;
  logic              accept, from_bad, to_bad, arc_bad;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign from_bad   = ({26'd0, from_state_i} >= 32'(MAX_STATES));
  assign to_bad     = ({26'd0, to_state_i} >= 32'(MAX_STATES));
  assign arc_bad    = from_bad || to_bad || (to_state_i <= from_state_i) ||
                      (from_state_i < prev_q);

  always_comb begin
    prev_d           = prev_q;
    err_d            = err_q;
    push_o           = 1'b0;
    cmd_o.op         = OP_ARC;
    cmd_o.err        = err_q;
    cmd_o.from_state = from_state_i;
    cmd_o.to_state   = to_state_i;
    cmd_o.weight     = arc_weight_i;
    cmd_o.in_label   = in_label_i;
    cmd_o.out_label  = out_label_i;
    if (accept) begin
      case (action_i)
        ACT_ARC: begin
          if (!err_q) begin
            if (arc_bad) begin
              err_d = 1'b1;
            end else begin
              prev_d = from_state_i;
              push_o = 1'b1;
            end
          end
        end
        ACT_MARK: begin
          cmd_o.op = OP_MARK;
          push_o   = !from_bad;
        end
        ACT_FINISH: begin
          cmd_o.op = OP_FINISH;
          push_o   = 1'b1;
          prev_d   = '0;
          err_d    = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      err_q  <= 1'b0;
    end else begin
      prev_q <= prev_d;
      err_q  <= err_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lbp_queue.sv
`default_nettype none
module lbp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lbp_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output lbp_pkg::cmd_t      cmd_o
);
  import lbp_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lbp_back.sv
`default_nettype none
module lbp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire lbp_pkg::cmd_t               cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [lbp_pkg::StateW-1:0]       position_o,
  output logic [lbp_pkg::LabelW-1:0]       path_in_label_o,
  output logic [lbp_pkg::LabelW-1:0]       path_out_label_o,
  output logic [lbp_pkg::WeightW-1:0]      path_weight_o,
  output logic                             last_o
);
  import lbp_pkg::*;

  back_state_e state_q, state_d;

  logic signed [CostW-1:0] cost_mem [Depth];
  logic [StateW-1:0]       pred_mem [Depth];
  arc_info_t               info_mem [Depth];
  logic [StateW-1:0]       stk_mem  [Depth];

  logic signed [CostW-1:0] cost_a_q, cost_b_q;
  logic [StateW-1:0]       pred_rd_q, stk_rd_q;
  arc_info_t               info_rd_q;

  cmd_t                    cmd_q;
  logic [Depth-1:0]        reached_q;
  logic signed [CostW-1:0] final_cost_q;
  logic [StateW-1:0]       final_pred_q;
  logic                    final_found_q;
  logic [StateW-1:0]       cur_q;
  logic [DepW-1:0]         dep_q;
  logic [StateW-1:0]       idx_q;
  logic                    fin_q;

  logic signed [CostW:0]   sum;
  logic signed [CostW-1:0] new_cost;
  logic                    relax_we, mark_we, trace_stop, handshake;
  logic [DepW-1:0]         dep_inc, stk_addr;

  assign sum       = {cost_a_q[CostW-1], cost_a_q} +
                     {{(CostW+1-WeightW){cmd_q.weight[WeightW-1]}}, cmd_q.weight};
  assign new_cost  = (sum[CostW] != sum[CostW-1]) ?
                     (sum[CostW] ? {1'b1, {(CostW-1){1'b0}}} : {1'b0, {(CostW-1){1'b1}}}) :
                     sum[CostW-1:0];
  assign dep_inc   = dep_q + 7'd1;
  assign stk_addr  = dep_q - 7'd2 - {1'b0, idx_q};
  assign trace_stop = (cur_q == '0) || (dep_inc == 7'(Depth));
  assign handshake = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          unique case (cmd_i.op)
            OP_ARC:  state_d = B_RELAX;
            OP_MARK: state_d = B_MARK;
            default: state_d = B_FINISH;
          endcase
        end
      end
      B_RELAX: state_d = B_IDLE;
      B_MARK:  state_d = B_IDLE;
      B_FINISH: state_d = (cmd_q.err || !final_found_q) ? B_OUT : B_TRACE;
      B_TRACE: begin
        if (!trace_stop) state_d = B_TNEXT;
        else if (dep_inc >= 7'd2) state_d = B_ERD1;
        else state_d = B_FINAL;
      end
      B_TNEXT: state_d = B_TRACE;
      B_ERD1:  state_d = B_ERD2;
      B_ERD2:  state_d = B_ERD3;
      B_ERD3:  state_d = B_OUT;
      B_FINAL: state_d = B_OUT;
      B_OUT: begin
        if (out_ready_i) begin
          if (fin_q) state_d = B_IDLE;
          else if ({1'b0, idx_q} + 7'd2 < dep_q) state_d = B_ERD1;
          else state_d = B_FINAL;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == B_IDLE) && valid_i;
    out_valid_o = (state_q == B_OUT);
    relax_we    = (state_q == B_RELAX) && reached_q[cmd_q.from_state] &&
                  (!reached_q[cmd_q.to_state] || (new_cost < cost_b_q));
    mark_we     = (state_q == B_MARK) && reached_q[cmd_q.from_state] &&
                  (!final_found_q || (cost_a_q < final_cost_q));
  end

  always_ff @(posedge clk_i) begin
    cost_a_q  <= (cmd_i.from_state == '0) ? '0 : cost_mem[cmd_i.from_state];
    cost_b_q  <= cost_mem[cmd_i.to_state];
    pred_rd_q <= pred_mem[cur_q];
    stk_rd_q  <= stk_mem[stk_addr[StateW-1:0]];
    info_rd_q <= info_mem[stk_rd_q];
    if (relax_we) begin
      cost_mem[cmd_q.to_state] <= new_cost;
      pred_mem[cmd_q.to_state] <= cmd_q.from_state;
      info_mem[cmd_q.to_state] <= '{weight: cmd_q.weight, in_label: cmd_q.in_label,
                                    out_label: cmd_q.out_label};
    end
    if (state_q == B_TRACE) begin
      stk_mem[dep_q[StateW-1:0]] <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (state_q == B_FINISH) begin
      cur_q <= final_pred_q;
      dep_q <= '0;
      idx_q <= '0;
    end
    if (state_q == B_TRACE) dep_q <= dep_inc;
    if (state_q == B_TNEXT) cur_q <= pred_rd_q;
    if (state_q == B_OUT && out_ready_i && !fin_q) idx_q <= idx_q + 6'd1;
    if (state_q == B_FINISH) begin
      kind_o           <= cmd_q.err ? KIND_ERROR : KIND_NONE;
      position_o       <= '0;
      path_in_label_o  <= '0;
      path_out_label_o <= '0;
      path_weight_o    <= '0;
      last_o           <= 1'b1;
    end else if (state_q == B_ERD3) begin
      kind_o           <= KIND_ARC;
      position_o       <= idx_q;
      path_in_label_o  <= info_rd_q.in_label;
      path_out_label_o <= info_rd_q.out_label;
      path_weight_o    <= info_rd_q.weight;
      last_o           <= 1'b0;
    end else if (state_q == B_FINAL) begin
      kind_o           <= KIND_FINAL;
      position_o       <= 6'(dep_q - 7'd1);
      path_in_label_o  <= '0;
      path_out_label_o <= '0;
      path_weight_o    <= '0;
      last_o           <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= B_IDLE;
      reached_q     <= {{(Depth-1){1'b0}}, 1'b1};
      final_cost_q  <= '0;
      final_pred_q  <= '0;
      final_found_q <= 1'b0;
      fin_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      if (relax_we) reached_q[cmd_q.to_state] <= 1'b1;
      if (mark_we) begin
        final_found_q <= 1'b1;
        final_cost_q  <= cost_a_q;
        final_pred_q  <= cmd_q.from_state;
      end
      if (state_q == B_FINISH) fin_q <= cmd_q.err || !final_found_q;
      if (state_q == B_FINAL) fin_q <= 1'b1;
      if (state_q == B_OUT && handshake && fin_q) begin
        fin_q         <= 1'b0;
        reached_q     <= {{(Depth-1){1'b0}}, 1'b1};
        final_cost_q  <= '0;
        final_pred_q  <= '0;
        final_found_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/lattice_best_path.sv
// Arc: pop with registered cost reads, then relax write. Final mark: pop, then mark.
// Finish: B_FINISH, then B_TRACE and B_TNEXT per path state to trace predecessors
// (B_TRACE alone for state 0), B_ERD1-3 and B_OUT per arc item, B_FINAL and B_OUT
// for the final item. A 2-entry command queue lets the front accept while the back
// works. Async active-low reset: only state 0 reached, no final, no order error.
`default_nettype none
module lattice_best_path #(
  parameter int MAX_STATES = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [lbp_pkg::StateW-1:0]  from_state_i,
  input  wire logic [lbp_pkg::StateW-1:0]  to_state_i,
  input  wire logic [lbp_pkg::WeightW-1:0] arc_weight_i,
  input  wire logic [lbp_pkg::LabelW-1:0]  in_label_i,
  input  wire logic [lbp_pkg::LabelW-1:0]  out_label_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [lbp_pkg::StateW-1:0]       position_o,
  output logic [lbp_pkg::LabelW-1:0]       path_in_label_o,
  output logic [lbp_pkg::LabelW-1:0]       path_out_label_o,
  output logic [lbp_pkg::WeightW-1:0]      path_weight_o,
  output logic                             last_o
);
  import lbp_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, q_valid;

  lbp_front #(.MAX_STATES(MAX_STATES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .from_state_i,
    .to_state_i, .arc_weight_i, .in_label_i, .out_label_i,
    .push_o(push), .full_i(full), .cmd_o(push_cmd)
  );

  lbp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(push_cmd), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .cmd_o(pop_cmd)
  );

  lbp_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .cmd_i(pop_cmd), .pop_o(pop),
    .out_valid_o, .out_ready_i, .kind_o, .position_o, .path_in_label_o,
    .path_out_label_o, .path_weight_o, .last_o
  );
endmodule
`default_nettype wire

// File: hw/rtl/lbp_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lbp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [1:0]                  kind_o,
  input wire logic [lbp_pkg::StateW-1:0]  position_o,
  input wire logic [lbp_pkg::LabelW-1:0]  path_in_label_o,
  input wire logic [lbp_pkg::LabelW-1:0]  path_out_label_o,
  input wire logic [lbp_pkg::WeightW-1:0] path_weight_o,
  input wire logic                        last_o
);
  import lbp_pkg::*;

  `LBP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(position_o) && $stable(last_o), "stalled result changed")
  `LBP_ASSERT(a_last_kind, out_valid_o |-> (last_o == (kind_o != KIND_ARC)), "last flag wrong")
  `LBP_ASSERT(a_zero_fields, out_valid_o && kind_o != KIND_ARC |-> path_in_label_o == '0 && path_out_label_o == '0 && path_weight_o == '0, "nonzero fields")
  `LBP_ASSERT(a_err_pos, out_valid_o && (kind_o == KIND_NONE || kind_o == KIND_ERROR) |-> position_o == '0, "error item position")
endmodule

bind lattice_best_path lbp_checker u_lbp_checker (.*);
`default_nettype wire
